// ===== sv/rce_pkg.sv =====
// Shared constants and types for the reflector cluster extractor.
// No dependencies; every other file of the block imports this package.
package rce_pkg;

  // Cluster size counter: 11 bits, saturating at 2047.
  localparam int CNT_W = 11;
  typedef logic [CNT_W-1:0] count_t;
  localparam count_t CNT_MAX = '1;

  localparam int INTEN_W     = 8;
  localparam int GATE_W      = 16;
  localparam int FIELD_R_W   = 16;
  localparam int INDEX_SUM_W = 20;
  localparam int FRAC_BITS   = 8;
  localparam int INDEX_Q_W   = 18;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MIN_BRIGHTNESS  = 3'd0;
  localparam cfg_idx_t REG_BACKGROUND_GATE = 3'd1;
  localparam cfg_idx_t REG_FEATURE_GATE    = 3'd2;
  localparam cfg_idx_t REG_MIN_CLUSTER     = 3'd3;
  localparam cfg_idx_t REG_RANGE_LIMIT     = 3'd4;

endpackage

// ===== sv/reflector_cluster_extractor_unit.sv =====
// Reflector cluster extractor: top level with the return sequencer and cluster state.
// Depends on rce_pkg, rce_sermul and rce_serdiv.
//
//   channel | dir | beat contents
//   s_*     | in  | one laser return (range, intensity, scan end on tlast)
//   m_*     | out | one reported cluster (mean range, mean index, size)
//   cfg_*   | in  | register write, taken at once
//
// A return that only moves the neighbour window passes the diff, decide and finish
// states. A return tested against an open cluster also waits on the two 11-step
// serial multipliers. A return that reports a cluster waits on the serial dividers,
// plus any wait while the previous result is still held.
// Synchronous reset restores the register defaults and empties the cluster.
// s_tready is high only between returns; a full output register stalls only a
// return that reports a new cluster.
module reflector_cluster_extractor_unit #(
  parameter int MAX_BEAMS  = 1024,
  parameter int RANGE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rce_pkg::S_DATA_W-1:0]     s_tdata,   // range_mm[15:0], intensity[23:16]
  input  logic                             s_tlast,   // scan_end
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rce_pkg::M_DATA_W-1:0]     m_tdata,   // mean_range_mm[15:0],
                                                      // mean_index_q8[33:16],
                                                      // cluster_size[44:34], zeros above
  input  logic                             cfg_we,
  input  logic [rce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rce_pkg::*;

  localparam int RW  = RANGE_BITS;
  localparam int SW  = RANGE_BITS + 10;
  localparam int CW  = (RW > GATE_W) ? RW : GATE_W;
  localparam int BW  = $clog2(MAX_BEAMS);
  localparam int PW  = RW + CNT_W;
  localparam int GW  = GATE_W + CNT_W;
  localparam int FW  = (PW > GW) ? PW : GW;
  localparam int IQW = INDEX_SUM_W + FRAC_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_FEAT   = 3'd4;
  localparam logic [2:0] ST_JOIN   = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  // Configuration registers.
  logic [INTEN_W-1:0] min_brightness;
  logic [GATE_W-1:0]  background_gate;
  logic [GATE_W-1:0]  feature_gate;
  count_t             min_cluster_returns;
  logic [GATE_W-1:0]  range_limit;

  logic [2:0]            state;
  logic [RW-1:0]         cur_range;
  logic [INTEN_W-1:0]    cur_intensity;
  logic                  cur_end;
  logic [RW-1:0]         older_range;
  logic [RW-1:0]         pending_range;
  logic [INTEN_W-1:0]    pending_intensity;
  logic [BW-1:0]         beam_counter;
  logic                  in_cluster;
  count_t                cluster_count;
  logic [SW-1:0]         range_sum;
  logic [INDEX_SUM_W-1:0] index_sum;
  logic [RW-1:0]         d_old;
  logic [RW-1:0]         d_new;
  logic [FW-1:0]         d_feat;

  logic [15:0]           m_range;
  logic [INDEX_Q_W-1:0]  m_index;
  count_t                m_size;

  logic                  mul_start;
  logic                  div_start;
  logic                  mul_r_busy;
  logic                  mul_g_busy;
  logic                  div_r_busy;
  logic                  div_i_busy;
  logic [PW-1:0]         prod_r;
  logic [GW-1:0]         prod_g;
  logic [SW-1:0]         q_range;
  logic [IQW-1:0]        q_index;

  logic [BW-1:0]         idx;
  logic                  qual;
  logic                  report;
  logic                  out_load;
  logic [FW-1:0]         fa;
  logic [FW-1:0]         fb;
  logic [SW:0]           range_sum_add;
  logic [INDEX_SUM_W:0]  index_sum_add;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(M_DATA_W - 16 - INDEX_Q_W - CNT_W){1'b0}}, m_size, m_index, m_range};

  assign idx = beam_counter - BW'(1);

  always_comb begin
    qual = (pending_intensity >= min_brightness) &&
           (CW'(pending_range) < CW'(range_limit)) &&
           ((CW'(d_old) < CW'(background_gate)) || (CW'(d_new) < CW'(background_gate)));
    report    = (cluster_count >= min_cluster_returns) && (cluster_count != '0);
    mul_start = (state == ST_DECIDE) && (beam_counter >= BW'(2)) && qual && in_cluster;
    div_start = (state == ST_DECIDE) && (beam_counter >= BW'(2)) && !qual && in_cluster &&
                report;
    out_load  = (state == ST_DIV) && !div_r_busy && !div_i_busy && (!m_tvalid || m_tready);
    fa = FW'(prod_r);
    fb = FW'(range_sum);
    range_sum_add = {1'b0, range_sum} + (SW+1)'(pending_range);
    index_sum_add = {1'b0, index_sum} + (INDEX_SUM_W+1)'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_brightness      <= INTEN_W'(1);
      background_gate     <= GATE_W'(300);
      feature_gate        <= GATE_W'(500);
      min_cluster_returns <= CNT_W'(1);
      range_limit         <= GATE_W'(8000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_BRIGHTNESS:  min_brightness      <= cfg_data[INTEN_W-1:0];
        REG_BACKGROUND_GATE: background_gate     <= cfg_data[GATE_W-1:0];
        REG_FEATURE_GATE:    feature_gate        <= cfg_data[GATE_W-1:0];
        REG_MIN_CLUSTER:     min_cluster_returns <= cfg_data[CNT_W-1:0];
        REG_RANGE_LIMIT:     range_limit         <= cfg_data[GATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      older_range       <= '0;
      pending_range     <= '0;
      pending_intensity <= '0;
      beam_counter      <= '0;
      in_cluster        <= 1'b0;
      cluster_count     <= '0;
      range_sum         <= '0;
      index_sum         <= '0;
      cur_end           <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_range     <= RW'(s_tdata[FIELD_R_W-1:0]);
            cur_intensity <= s_tdata[FIELD_R_W+INTEN_W-1:FIELD_R_W];
            cur_end       <= s_tlast;
            state         <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          d_old <= (older_range >= pending_range) ? older_range - pending_range
                                                  : pending_range - older_range;
          d_new <= (cur_range >= pending_range) ? cur_range - pending_range
                                                : pending_range - cur_range;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (mul_start) begin
            state <= ST_MUL;
          end else if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_FINISH;
          end
          if (beam_counter >= BW'(2)) begin
            if (qual && !in_cluster) begin
              // Beam indexes are BW bits wide (10 by default), so the index sum cannot clip here.
              in_cluster    <= 1'b1;
              cluster_count <= CNT_W'(1);
              range_sum     <= SW'(pending_range);
              index_sum     <= INDEX_SUM_W'(idx);
            end else if (!qual && in_cluster) begin
              in_cluster <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          if (!mul_r_busy && !mul_g_busy) begin
            state <= ST_FEAT;
          end
        end
        ST_FEAT: begin
          d_feat <= (fa >= fb) ? fa - fb : fb - fa;
          state  <= ST_JOIN;
        end
        ST_JOIN: begin
          if (d_feat < FW'(prod_g)) begin
            if (cluster_count != CNT_MAX) begin
              cluster_count <= cluster_count + CNT_W'(1);
            end
            range_sum <= range_sum_add[SW] ? '1 : range_sum_add[SW-1:0];
            index_sum <= index_sum_add[INDEX_SUM_W] ? '1 : index_sum_add[INDEX_SUM_W-1:0];
          end
          state <= ST_FINISH;
        end
        ST_DIV: begin
          if (out_load) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // The last return of a scan empties the window and drops an open cluster.
          if (cur_end) begin
            older_range       <= '0;
            pending_range     <= '0;
            pending_intensity <= '0;
            beam_counter      <= '0;
            in_cluster        <= 1'b0;
            cluster_count     <= '0;
            range_sum         <= '0;
            index_sum         <= '0;
          end else begin
            older_range       <= pending_range;
            pending_range     <= cur_range;
            pending_intensity <= cur_intensity;
            if (beam_counter < BW'(MAX_BEAMS - 1)) begin
              beam_counter <= beam_counter + BW'(1);
            end
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_range <= 16'(q_range);
      m_index <= q_index[INDEX_Q_W-1:0];
      m_size  <= cluster_count;
    end
  end

  rce_sermul #(.AW(RW)) u_mul_range (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (pending_range),
    .multiplier   (cluster_count),
    .busy         (mul_r_busy),
    .product      (prod_r)
  );

  rce_sermul #(.AW(GATE_W)) u_mul_gate (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (feature_gate),
    .multiplier   (cluster_count),
    .busy         (mul_g_busy),
    .product      (prod_g)
  );

  rce_serdiv #(.DW(SW)) u_div_range (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (range_sum),
    .divisor  (cluster_count),
    .busy     (div_r_busy),
    .quotient (q_range)
  );

  rce_serdiv #(.DW(IQW)) u_div_index (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({index_sum, FRAC_BITS'(0)}),
    .divisor  (cluster_count),
    .busy     (div_i_busy),
    .quotient (q_index)
  );

  a_open_count: assert property (@(posedge clk) disable iff (rst)
    in_cluster |-> cluster_count != '0)
    else $error("open cluster with zero returns");

  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    !((mul_r_busy || mul_g_busy) && (div_r_busy || div_i_busy)))
    else $error("multiplier and divider busy together");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mul_r_busy && !mul_g_busy && !div_r_busy && !div_i_busy)
    else $error("arithmetic unit busy between returns");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_size != '0)
    else $error("reported cluster has zero size");

  a_beam_bound: assert property (@(posedge clk) disable iff (rst)
    beam_counter <= BW'(MAX_BEAMS - 1))
    else $error("beam counter beyond last beam");

endmodule

// ===== sv/rce_sermul.sv =====
// Bit-serial multiplier: operand times an 11-bit count, one count bit per cycle.
// Depends on rce_pkg for the count type.
module rce_sermul #(
  parameter int AW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [AW-1:0]       multiplicand,
  input  rce_pkg::count_t     multiplier,
  output logic                busy,
  output logic [AW+rce_pkg::CNT_W-1:0] product
);
  import rce_pkg::*;

  localparam int CTW = $clog2(CNT_W);

  logic [AW-1:0]    op;
  logic [AW-1:0]    acc;
  logic [CNT_W-1:0] lo;
  count_t           mbits;
  logic [CTW-1:0]   cnt;
  logic [AW:0]      sum;

  // LSB first: each cycle adds the operand when the multiplier bit is set and
  // retires one finished product bit into the low shift register.
  assign sum = {1'b0, acc} + (mbits[0] ? {1'b0, op} : '0);
  assign product = {acc, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CTW'(CNT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op    <= multiplicand;
      mbits <= multiplier;
      acc   <= '0;
      lo    <= '0;
    end else if (busy) begin
      acc   <= sum[AW:1];
      lo    <= {sum[0], lo[CNT_W-1:1]};
      mbits <= mbits >> 1;
    end
  end

endmodule

// ===== sv/rce_serdiv.sv =====
// Restoring divider by an 11-bit count, one quotient bit per cycle.
// Depends on rce_pkg for the count type.
module rce_serdiv #(
  parameter int DW = 28
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DW-1:0]   dividend,
  input  rce_pkg::count_t divisor,
  output logic            busy,
  output logic [DW-1:0]   quotient
);
  import rce_pkg::*;

  localparam int CTW = $clog2(DW);

  count_t           dvs;
  count_t           rem;
  logic [DW-1:0]    shreg;
  logic [CTW-1:0]   cnt;
  logic [CNT_W:0]   trial;
  logic [CNT_W+1:0] diff;
  logic             ge;

  // Dividend bits leave at the top of the shift register while quotient bits
  // enter at the bottom; the remainder stays below any nonzero divisor.
  assign trial    = {rem, shreg[DW-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs};
  assign ge       = !diff[CNT_W+1];
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CTW'(DW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs   <= divisor;
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      shreg <= {shreg[DW-2:0], ge};
    end
  end

endmodule
